FILE: hdl/tgff_pkg.sv
// Shared widths, register indexes and region codes for the three-grade fuzzifier.
package tgff_pkg;

  localparam int VALUE_WIDTH = 48;
  localparam int FRAC_BITS   = 16;
  localparam int SPLIT_BITS  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam int DIFF_W  = VALUE_WIDTH + 1;
  localparam int NUM_W   = DIFF_W + SPLIT_BITS;
  localparam int DEN_W   = NUM_W + 1;
  localparam int GRADE_W = FRAC_BITS + 1;

  localparam logic [GRADE_W-1:0]  GRADE_ONE = GRADE_W'(1) << FRAC_BITS;
  localparam logic [SPLIT_BITS:0] SPLIT_ONE = (SPLIT_BITS + 1)'(1) << SPLIT_BITS;
  localparam logic [SPLIT_BITS-1:0] SPLIT_RESET = SPLIT_BITS'(13107);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_START    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_END      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_START    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_END      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_FRACTION = 3'd5;

  // Shape modes
  localparam logic [1:0] MODE_LOWER_BETTER  = 2'd0;
  localparam logic [1:0] MODE_HIGHER_BETTER = 2'd1;

  // Region codes: which grades take one, the ratio g, or one minus g
  localparam logic [1:0] KIND_WEAK_ONE   = 2'd0;
  localparam logic [1:0] KIND_STRONG_ONE = 2'd1;
  localparam logic [1:0] KIND_MED_WEAK   = 2'd2;
  localparam logic [1:0] KIND_MED_STRONG = 2'd3;

  typedef struct packed {
    logic [DIFF_W-1:0] xu;
    logic [DIFF_W-1:0] tx;
    logic [DIFF_W-1:0] xtt;
    logic [DIFF_W-1:0] uux;
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] dd;
    logic x_lt_u;
    logic x_lt_t;
    logic x_lt_tt;
    logic x_lt_uu;
    logic rok;
    logic fok;
    logic degen;
  } diff_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [FRAC_BITS-1:0] quo;
    logic sat;
    logic [1:0] kind;
    logic degen;
  } div_t;

endpackage

FILE: hdl/three_grade_fuzzy_fuzzifier_unit.sv
// Three-grade fuzzifier: piecewise-linear weak/medium/strong grades, pipelined.
//
// Use: write the shape registers through cfg_we/cfg_index/cfg_data while no
// item is in flight, then pulse start with in_sample_value. busy stays low,
// so a new sample may be given on every clock.
// Each item gives one result: out_valid is high for one cycle with the
// weak, medium and strong grades (Q1.16, 65536 is one) and degenerate_ramp.
// Throughput: one item per cycle. The figure is set by the restoring
// divider, unrolled into one pipeline stage per quotient bit (16 stages),
// behind a difference stage, a partial-product stage, a product-sum stage,
// a region-select stage, and followed by the output register.
// Reset clears all valid bits and loads the register defaults (split
// fraction 13107, all else zero); items in flight are dropped.
// The receiver cannot stall: each result is taken in the cycle it shows.
module three_grade_fuzzy_fuzzifier_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [tgff_pkg::VALUE_WIDTH-1:0] in_sample_value,
  output logic out_valid,
  output logic [tgff_pkg::GRADE_W-1:0] out_weak_grade,
  output logic [tgff_pkg::GRADE_W-1:0] out_medium_grade,
  output logic [tgff_pkg::GRADE_W-1:0] out_strong_grade,
  output logic out_degenerate_ramp,
  input  logic cfg_we,
  input  logic [tgff_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tgff_pkg::VALUE_WIDTH-1:0] cfg_data
);

  localparam int VW = tgff_pkg::VALUE_WIDTH;
  localparam int DW = tgff_pkg::DIFF_W;
  localparam int NW = tgff_pkg::NUM_W;
  localparam int EW = tgff_pkg::DEN_W;
  localparam int FB = tgff_pkg::FRAC_BITS;
  localparam int SB = tgff_pkg::SPLIT_BITS;
  localparam int GW = tgff_pkg::GRADE_W;
  localparam int LW = DW / 2;
  localparam int HW = DW - LW;

  // Configuration registers
  logic [1:0]    shape_mode_r;
  logic [VW-1:0] lower_start_r, lower_end_r, upper_start_r, upper_end_r;
  logic [SB-1:0] split_fraction_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r     <= tgff_pkg::MODE_LOWER_BETTER;
      lower_start_r    <= '0;
      lower_end_r      <= '0;
      upper_start_r    <= '0;
      upper_end_r      <= '0;
      split_fraction_r <= tgff_pkg::SPLIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tgff_pkg::REG_SHAPE_MODE:     shape_mode_r     <= cfg_data[1:0];
        tgff_pkg::REG_LOWER_START:    lower_start_r    <= cfg_data;
        tgff_pkg::REG_LOWER_END:      lower_end_r      <= cfg_data;
        tgff_pkg::REG_UPPER_START:    upper_start_r    <= cfg_data;
        tgff_pkg::REG_UPPER_END:      upper_end_r      <= cfg_data;
        tgff_pkg::REG_SPLIT_FRACTION: split_fraction_r <= cfg_data[SB-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic rising, falling;
  assign rising  = (shape_mode_r != tgff_pkg::MODE_LOWER_BETTER);
  assign falling = (shape_mode_r != tgff_pkg::MODE_HIGHER_BETTER);

  function automatic logic [DW-1:0] sdiff(input logic [VW-1:0] p, input logic [VW-1:0] q);
    sdiff = {p[VW-1], p} - {q[VW-1], q};
  endfunction

  // Stage 1: differences and breakpoint compares
  logic          v1_r;
  tgff_pkg::diff_t s1_nxt, s1_r;

  always_comb begin
    s1_nxt.xu      = sdiff(in_sample_value, lower_start_r);
    s1_nxt.tx      = sdiff(lower_end_r, in_sample_value);
    s1_nxt.xtt     = sdiff(in_sample_value, upper_start_r);
    s1_nxt.uux     = sdiff(upper_end_r, in_sample_value);
    s1_nxt.d       = sdiff(lower_end_r, lower_start_r);
    s1_nxt.dd      = sdiff(upper_end_r, upper_start_r);
    s1_nxt.x_lt_u  = $signed(in_sample_value) < $signed(lower_start_r);
    s1_nxt.x_lt_t  = $signed(in_sample_value) < $signed(lower_end_r);
    s1_nxt.x_lt_tt = $signed(in_sample_value) < $signed(upper_start_r);
    s1_nxt.x_lt_uu = $signed(in_sample_value) < $signed(upper_end_r);
    s1_nxt.rok     = $signed(lower_end_r) > $signed(lower_start_r);
    s1_nxt.fok     = $signed(upper_end_r) > $signed(upper_start_r);
    s1_nxt.degen   = (rising && !s1_nxt.rok) || (falling && !s1_nxt.fok);
  end

  // Stage 2: partial products of the ramp widths and the split fraction
  logic          v2_r;
  tgff_pkg::diff_t s2_r;
  logic [LW+SB:0] ad_lo_r, bd1_lo_r, bd_lo_r, ad2_lo_r;
  logic [HW+SB:0] ad_hi_r, bd1_hi_r, bd_hi_r, ad2_hi_r;
  logic [SB:0]   a_w, a1_w;

  assign a_w  = {1'b0, split_fraction_r};
  assign a1_w = tgff_pkg::SPLIT_ONE - a_w;

  function automatic logic [LW+SB:0] mul_lo(input logic [LW-1:0] p, input logic [SB:0] q);
    mul_lo = {{(SB+1){1'b0}}, p} * {{LW{1'b0}}, q};
  endfunction

  function automatic logic [HW+SB:0] mul_hi(input logic [HW-1:0] p, input logic [SB:0] q);
    mul_hi = {{(SB+1){1'b0}}, p} * {{HW{1'b0}}, q};
  endfunction

  function automatic logic [EW-1:0] mul_sum(input logic [HW+SB:0] hi,
                                            input logic [LW+SB:0] lo);
    mul_sum = {hi, LW'(0)} + EW'(lo);
  endfunction

  // Stage 2b: ramp widths scaled by the split fraction and by one minus it
  logic          v2b_r;
  tgff_pkg::diff_t s2b_r;
  logic [EW-1:0] ad_r, bd1_r, bd_r, ad2_r;

  // Stage 3: region select, divider operands
  logic          v3_r;
  tgff_pkg::div_t s3_nxt, s3_r;

  always_comb begin
    logic [NW-1:0] pn, pn2, num;
    logic [EW-1:0] den;
    logic [1:0]    kind;
    logic          done;
    pn   = {s2b_r.xu, SB'(0)};
    pn2  = {s2b_r.xtt, SB'(0)};
    num  = '0;
    den  = '0;
    kind = tgff_pkg::KIND_WEAK_ONE;
    done = 1'b0;
    if (rising) begin
      if (s2b_r.x_lt_u) begin
        kind = tgff_pkg::KIND_WEAK_ONE;
        done = 1'b1;
      end else if (s2b_r.rok) begin
        if ({1'b0, pn} < ad_r) begin
          num  = pn;
          den  = ad_r;
          kind = tgff_pkg::KIND_MED_WEAK;
          done = 1'b1;
        end else if (s2b_r.x_lt_t) begin
          num  = {s2b_r.tx, SB'(0)};
          den  = bd1_r;
          kind = tgff_pkg::KIND_MED_STRONG;
          done = 1'b1;
        end
      end
    end
    if (!done) begin
      if (!falling || s2b_r.x_lt_tt) begin
        kind = tgff_pkg::KIND_STRONG_ONE;
      end else if (!s2b_r.fok) begin
        kind = tgff_pkg::KIND_WEAK_ONE;
      end else if ({1'b0, pn2} < bd_r) begin
        num  = pn2;
        den  = bd_r;
        kind = tgff_pkg::KIND_MED_STRONG;
      end else if (s2b_r.x_lt_uu) begin
        num  = {s2b_r.uux, SB'(0)};
        den  = ad2_r;
        kind = tgff_pkg::KIND_MED_WEAK;
      end else begin
        kind = tgff_pkg::KIND_WEAK_ONE;
      end
    end
    s3_nxt.rem   = {1'b0, num};
    s3_nxt.den   = den;
    s3_nxt.quo   = '0;
    s3_nxt.sat   = ({1'b0, num} >= den) && (num != '0);
    s3_nxt.kind  = kind;
    s3_nxt.degen = s2b_r.degen;
  end

  // Divider: one quotient bit per stage
  function automatic tgff_pkg::div_t div_step(input tgff_pkg::div_t cur);
    tgff_pkg::div_t nxt;
    logic [EW:0] sh;
    logic        ge;
    nxt = cur;
    sh  = {cur.rem, 1'b0};
    ge  = sh >= {1'b0, cur.den};
    nxt.rem = ge ? EW'(sh - {1'b0, cur.den}) : EW'(sh);
    nxt.quo = {cur.quo[FB-2:0], ge};
    return nxt;
  endfunction

  logic [FB-1:0]  dv_r;
  tgff_pkg::div_t div_r [FB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v2b_r     <= 1'b0;
      v3_r      <= 1'b0;
      dv_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      v1_r      <= start && !busy;
      v2_r      <= v1_r;
      v2b_r     <= v2_r;
      v3_r      <= v2b_r;
      dv_r      <= {dv_r[FB-2:0], v3_r};
      out_valid <= dv_r[FB-1];
    end
  end

  logic [GW-1:0] g_w;
  assign g_w = div_r[FB-1].sat ? tgff_pkg::GRADE_ONE : {1'b0, div_r[FB-1].quo};

  always_ff @(posedge clk) begin
    s1_r     <= s1_nxt;
    s2_r     <= s1_r;
    ad_lo_r  <= mul_lo(s1_r.d[LW-1:0], a_w);
    ad_hi_r  <= mul_hi(s1_r.d[DW-1:LW], a_w);
    bd1_lo_r <= mul_lo(s1_r.d[LW-1:0], a1_w);
    bd1_hi_r <= mul_hi(s1_r.d[DW-1:LW], a1_w);
    bd_lo_r  <= mul_lo(s1_r.dd[LW-1:0], a1_w);
    bd_hi_r  <= mul_hi(s1_r.dd[DW-1:LW], a1_w);
    ad2_lo_r <= mul_lo(s1_r.dd[LW-1:0], a_w);
    ad2_hi_r <= mul_hi(s1_r.dd[DW-1:LW], a_w);
    s2b_r    <= s2_r;
    ad_r     <= mul_sum(ad_hi_r, ad_lo_r);
    bd1_r    <= mul_sum(bd1_hi_r, bd1_lo_r);
    bd_r     <= mul_sum(bd_hi_r, bd_lo_r);
    ad2_r    <= mul_sum(ad2_hi_r, ad2_lo_r);
    s3_r     <= s3_nxt;
    div_r[0] <= div_step(s3_r);
    for (int i = 1; i < FB; i++) begin
      div_r[i] <= div_step(div_r[i-1]);
    end
    out_degenerate_ramp <= div_r[FB-1].degen;
    unique case (div_r[FB-1].kind)
      tgff_pkg::KIND_WEAK_ONE: begin
        out_weak_grade   <= tgff_pkg::GRADE_ONE;
        out_medium_grade <= '0;
        out_strong_grade <= '0;
      end
      tgff_pkg::KIND_STRONG_ONE: begin
        out_weak_grade   <= '0;
        out_medium_grade <= '0;
        out_strong_grade <= tgff_pkg::GRADE_ONE;
      end
      tgff_pkg::KIND_MED_WEAK: begin
        out_weak_grade   <= tgff_pkg::GRADE_ONE - g_w;
        out_medium_grade <= g_w;
        out_strong_grade <= '0;
      end
      tgff_pkg::KIND_MED_STRONG: begin
        out_weak_grade   <= '0;
        out_medium_grade <= g_w;
        out_strong_grade <= tgff_pkg::GRADE_ONE - g_w;
      end
    endcase
  end

  // The three grades of a result always add to one
  a_grade_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (GW + 1)'(out_weak_grade) + (GW + 1)'(out_medium_grade)
                  + (GW + 1)'(out_strong_grade) == (GW + 1)'(tgff_pkg::GRADE_ONE))
    else $error("grades do not sum to one");

  // Every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##21 out_valid)
    else $error("result missing after pipeline latency");

  // No result without an item at the tail of the divider
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(dv_r[FB-1]))
    else $error("result without item");

  // Saturated ratio only where the divider holds real operands
  a_sat_den: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && s3_r.sat) |-> (s3_r.kind == tgff_pkg::KIND_MED_WEAK
                            || s3_r.kind == tgff_pkg::KIND_MED_STRONG))
    else $error("saturated ratio in a constant region");

endmodule

FILE: sim/tb_three_grade_fuzzy_fuzzifier_unit.sv
// Testbench for the three-grade fuzzifier: directed and random samples checked against a predictor.
module tb_three_grade_fuzzy_fuzzifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_WIDTH = tgff_pkg::VALUE_WIDTH;
  localparam int GRADE_W     = tgff_pkg::GRADE_W;
  localparam int CFG_INDEX_W = tgff_pkg::CFG_INDEX_W;
  localparam int SPLIT_BITS  = tgff_pkg::SPLIT_BITS;
  localparam int FRAC_BITS   = tgff_pkg::FRAC_BITS;

  localparam logic [1:0] MODE_MIDDLE_BAND = 2'd2;
  localparam logic [1:0] MODE_SPARE       = 2'd3;
  localparam int PIPE_DRAIN = 30;
  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [GRADE_W-1:0] w_grade;
    logic [GRADE_W-1:0] m_grade;
    logic [GRADE_W-1:0] s_grade;
    logic               degen;
  } grades_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [VALUE_WIDTH-1:0] in_sample_value = '0;
  logic out_valid;
  logic [GRADE_W-1:0] out_weak_grade, out_medium_grade, out_strong_grade;
  logic out_degenerate_ramp;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [VALUE_WIDTH-1:0] cfg_data = '0;

  // shadow copy of the shape registers
  logic [1:0]             shape_mode;
  logic [VALUE_WIDTH-1:0] lower_start, lower_end, upper_start, upper_end;
  logic [SPLIT_BITS-1:0]  split_fraction;

  grades_t pending_grades[$];
  int      error_count = 0;

  three_grade_fuzzy_fuzzifier_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // floor(num * 2^FRAC_BITS / den), saturated at one
  function automatic logic [GRADE_W-1:0] ramp_ratio(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (num == 0) return '0;
    if (num >= den) return tgff_pkg::GRADE_ONE;
    q = (num << FRAC_BITS) / den;
    return q[GRADE_W-1:0];
  endfunction

  function automatic grades_t grade_sample(logic [VALUE_WIDTH-1:0] xv);
    logic signed [VALUE_WIDTH:0] x, u, t, tt, uu;
    logic [127:0] d, dd, pn, a, na;
    logic [GRADE_W-1:0] w, md, s, g;
    bit rising, falling, rok, fok, done;
    grades_t r;
    x = {xv[VALUE_WIDTH-1], xv};
    u = {lower_start[VALUE_WIDTH-1], lower_start};
    t = {lower_end[VALUE_WIDTH-1], lower_end};
    tt = {upper_start[VALUE_WIDTH-1], upper_start};
    uu = {upper_end[VALUE_WIDTH-1], upper_end};
    a = 128'(split_fraction);
    na = 128'(tgff_pkg::SPLIT_ONE) - a;
    rising = shape_mode != tgff_pkg::MODE_LOWER_BETTER;
    falling = shape_mode != tgff_pkg::MODE_HIGHER_BETTER;
    rok = t > u;
    fok = uu > tt;
    done = 0;
    w = '0; md = '0; s = '0;
    if (rising) begin
      if (x < u) begin
        w = tgff_pkg::GRADE_ONE; done = 1;
      end else if (rok) begin
        d = 128'($unsigned(t - u));
        pn = 128'($unsigned(x - u)) << SPLIT_BITS;
        if (pn < d * a) begin
          g = ramp_ratio(pn, d * a);
          md = g; w = tgff_pkg::GRADE_ONE - g; done = 1;
        end else if (x < t) begin
          g = ramp_ratio(128'($unsigned(t - x)) << SPLIT_BITS, d * na);
          md = g; s = tgff_pkg::GRADE_ONE - g; done = 1;
        end
      end
    end
    if (!done && !falling) begin
      s = tgff_pkg::GRADE_ONE; done = 1;
    end
    if (!done) begin
      if (x < tt) begin
        s = tgff_pkg::GRADE_ONE;
      end else if (!fok) begin
        w = tgff_pkg::GRADE_ONE;
      end else begin
        dd = 128'($unsigned(uu - tt));
        pn = 128'($unsigned(x - tt)) << SPLIT_BITS;
        if (pn < dd * na) begin
          g = ramp_ratio(pn, dd * na);
          md = g; s = tgff_pkg::GRADE_ONE - g;
        end else if (x < uu) begin
          g = ramp_ratio(128'($unsigned(uu - x)) << SPLIT_BITS, dd * a);
          md = g; w = tgff_pkg::GRADE_ONE - g;
        end else begin
          w = tgff_pkg::GRADE_ONE;
        end
      end
    end
    if (w == tgff_pkg::GRADE_ONE) begin
      md = '0; s = '0;
    end else if (md == tgff_pkg::GRADE_ONE) begin
      w = '0; s = '0;
    end else if (s == tgff_pkg::GRADE_ONE) begin
      w = '0; md = '0;
    end
    r.w_grade = w; r.m_grade = md; r.s_grade = s;
    r.degen = (rising && !rok) || (falling && !fok);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    grades_t want;
    if (rst_n && out_valid) begin
      if (pending_grades.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_grades.pop_front();
        if (out_weak_grade !== want.w_grade)
          report_mismatch("weak_grade", out_weak_grade, want.w_grade);
        if (out_medium_grade !== want.m_grade)
          report_mismatch("medium_grade", out_medium_grade, want.m_grade);
        if (out_strong_grade !== want.s_grade)
          report_mismatch("strong_grade", out_strong_grade, want.s_grade);
        if (out_degenerate_ramp !== want.degen)
          report_mismatch("degenerate_ramp", out_degenerate_ramp, want.degen);
      end
    end
  end

  // hold start high; the caller drops it through idle_cycles
  task automatic send_sample(logic [VALUE_WIDTH-1:0] x);
    start <= 1'b1;
    in_sample_value <= x;
    do @(posedge clk); while (busy);
    pending_grades = {pending_grades, grade_sample(x)};
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) idle_cycles(0);
    else if (r < 92) idle_cycles($urandom_range(1, 3));
    else idle_cycles($urandom_range(10, 40));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_grades.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [VALUE_WIDTH-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tgff_pkg::REG_SHAPE_MODE:     shape_mode = data[1:0];
      tgff_pkg::REG_LOWER_START:    lower_start = data;
      tgff_pkg::REG_LOWER_END:      lower_end = data;
      tgff_pkg::REG_UPPER_START:    upper_start = data;
      tgff_pkg::REG_UPPER_END:      upper_end = data;
      tgff_pkg::REG_SPLIT_FRACTION: split_fraction = data[SPLIT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(logic [1:0] mode, logic [VALUE_WIDTH-1:0] u, logic [VALUE_WIDTH-1:0] t,
                           logic [VALUE_WIDTH-1:0] tt, logic [VALUE_WIDTH-1:0] uu,
                           logic [SPLIT_BITS-1:0] a);
    drain();
    write_reg(tgff_pkg::REG_SHAPE_MODE, VALUE_WIDTH'(mode));
    write_reg(tgff_pkg::REG_LOWER_START, u);
    write_reg(tgff_pkg::REG_LOWER_END, t);
    write_reg(tgff_pkg::REG_UPPER_START, tt);
    write_reg(tgff_pkg::REG_UPPER_END, uu);
    write_reg(tgff_pkg::REG_SPLIT_FRACTION, VALUE_WIDTH'(a));
  endtask

  function automatic logic [VALUE_WIDTH-1:0] rand_value();
    return VALUE_WIDTH'({$urandom, $urandom});
  endfunction

  // values in Q32.16: 48'sd65536 is one unit
  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(-48'sd1);
    send_sample(48'sd1);
  endtask

  task automatic test_lower_better();
    set_shape(tgff_pkg::MODE_LOWER_BETTER, '0, '0, 48'sd655360, 48'sd1310720, 16'd13107);
    send_sample(48'sd655359);
    send_sample(48'sd655360);
    send_sample(48'sd786432);
    send_sample(48'sd1179648);
    send_sample(48'sd1310720);
  endtask

  task automatic test_higher_better();
    set_shape(tgff_pkg::MODE_HIGHER_BETTER, -48'sd65536, 48'sd65536, '0, '0, 16'd65535);
    send_sample(-48'sd65537);
    send_sample(-48'sd65536);
    send_sample(48'sd65534);
    send_sample(48'sd65536);
  endtask

  task automatic test_middle_band_extremes();
    set_shape(MODE_MIDDLE_BAND, VAL_MIN, -48'sd1, 48'sd1, VAL_MAX, 16'd1);
    send_sample(VAL_MIN);
    send_sample(VAL_MAX);
    send_sample('0);
    send_sample(-48'sd2);
  endtask

  task automatic test_split_zero_and_mode_three();
    set_shape(MODE_SPARE, '0, 48'sd100, 48'sd200, 48'sd300, 16'd0);
    send_sample('0);
    send_sample(48'sd50);
    send_sample(48'sd250);
    send_sample(48'sd300);
  endtask

  task automatic test_degenerate_ramps();
    set_shape(MODE_MIDDLE_BAND, 48'sd500, 48'sd500, 48'sd900, 48'sd800, 16'd32768);
    send_sample(48'sd499);
    send_sample(48'sd500);
    send_sample(48'sd899);
    send_sample(48'sd900);
  endtask

  task automatic random_shape();
    logic [VALUE_WIDTH-1:0] base, p1, p2, p3;
    logic [1:0] mode;
    logic [SPLIT_BITS-1:0] a;
    int r;
    mode = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 9);
    a = (r == 0) ? SPLIT_BITS'($urandom_range(0, 1)) :
        (r == 1) ? 16'hFFFF : SPLIT_BITS'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      set_shape(mode, rand_value(), rand_value(), rand_value(), rand_value(), a);
    end else begin
      base = $signed(rand_value()) >>> $urandom_range(8, 47);
      r = $urandom_range(0, 30);
      p1 = base + VALUE_WIDTH'($urandom_range(0, 1 << r) * ($urandom_range(0, 9) != 0));
      p2 = p1 + VALUE_WIDTH'($urandom_range(0, 1 << r));
      p3 = p2 + VALUE_WIDTH'($urandom_range(0, 1 << r) * ($urandom_range(0, 9) != 0));
      set_shape(mode, base, p1, p2, p3, a);
    end
  endtask

  function automatic logic [VALUE_WIDTH-1:0] random_sample();
    logic [VALUE_WIDTH-1:0] anchor;
    case ($urandom_range(0, 5))
      0: anchor = lower_start;
      1: anchor = lower_end;
      2: anchor = upper_start;
      3: anchor = upper_end;
      4: return rand_value();
      default: return lower_start + VALUE_WIDTH'($unsigned(upper_end - lower_start) / 48'd7)
                 * VALUE_WIDTH'($urandom_range(0, 7));
    endcase
    return anchor + VALUE_WIDTH'($signed($urandom_range(0, 1 << $urandom_range(0, 30)))
           * ($urandom_range(0, 1) ? 1 : -1));
  endfunction

  task automatic test_random_stream();
    for (int phase = 0; phase < 40; phase++) begin
      random_shape();
      for (int k = 0; k < 20; k++) begin
        send_sample(random_sample());
        random_gap();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    shape_mode = tgff_pkg::MODE_LOWER_BETTER;
    lower_start = '0; lower_end = '0; upper_start = '0; upper_end = '0;
    split_fraction = tgff_pkg::SPLIT_RESET;
    @(posedge clk);
    test_reset_defaults();
    test_lower_better();
    test_higher_better();
    test_middle_band_extremes();
    test_split_zero_and_mode_three();
    test_degenerate_ramps();
    test_random_stream();
    drain();
    if (error_count == 0 && pending_grades.size() == 0) begin
      $display("tb_three_grade_fuzzy_fuzzifier_unit: PASS");
    end else begin
      $display("tb_three_grade_fuzzy_fuzzifier_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_three_grade_fuzzy_fuzzifier_unit: FAIL");
    $finish;
  end

endmodule
